[hw/rtl/rcdz_pkg.sv]
// Shared types and constants of the dead-zone skid-steer mixer.
package rcdz_pkg;

    // Configuration port register indexes.
    localparam int CFG_ADDR_BITS = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_ELEVATOR_CAL  = 3'd0,
        REG_AILERON_CAL   = 3'd1,
        REG_RUDDER_CAL    = 3'd2,
        REG_ARM_THRESHOLD = 3'd3,
        REG_DEAD_BAND     = 3'd4,
        REG_HARD_STOP     = 3'd5
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam int CAL_RESET_VALUE  = 1000;
    localparam int ARM_RESET_VALUE  = 1000;
    localparam int DEAD_BAND_RESET  = 20;

    // Stick axis processed by the shared divider.
    typedef enum logic [1:0] {
        AXIS_AIL = 2'd0,
        AXIS_ELE = 2'd1,
        AXIS_RUD = 2'd2
    } axis_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_CHECK  = 3'd1,
        ST_SETUP  = 3'd2,
        ST_DIV    = 3'd3,
        ST_STORE  = 3'd4,
        ST_FINISH = 3'd5
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  div_start;
        logic  store;
        logic  finish;
        axis_t axis;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic div_done;
    } dp_status_t;

endpackage

[hw/rtl/rc_deadzone_skid_steer_mixer_unit.sv]
// Top level of the dead-zone skid-steer mixer with stream and configuration ports.
//
// This block turns one decoded radio frame (aileron, elevator, rudder and arm
// channels plus the receiver's failsafe and lost-frame flags) into four
// half-bridge PWM duties and a bridge enable for a two-track drive. Each
// stick axis is zero inside its center plus or minus the dead band and is
// otherwise scaled linearly toward its calibrated end point into a signed
// value; rotation on the rudder wins, else the elevator drives forward or
// backward with the aileron turning. A low arm channel or failsafe forces
// every duty and the enable to zero, and a lost frame while armed repeats
// the last result. Every accepted request yields exactly one result request.
// The three axes share one restoring divider that retires one quotient bit
// per cycle, so between acceptance and the next acceptance a full frame
// runs setup, divide and store once for each axis before the finish; a
// disarmed or lost frame bypasses the divider and goes to the finish. The
// finished result sits in an output register, so the block takes the next
// frame while that result still waits; it only stalls at the end of the
// next frame if the result has not been taken by then. Configuration
// writes are accepted in every cycle and must only be issued while no
// frame is in flight.
module rc_deadzone_skid_steer_mixer_unit
    import rcdz_pkg::*;
#(
    parameter int CHANNEL_BITS = 11,
    parameter int DUTY_BITS    = 8
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,

    // Input frame stream.
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata from bit 0 up: ch_aileron, ch_elevator, ch_rudder, ch_arm,
    // then zero padding to a whole byte.
    input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // tuser from bit 0 up: failsafe_flag, frame_lost.
    input  logic [1:0]                                s_axis_tuser,

    // Output duty stream.
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // tdata from bit 0 up: duty_left_a, duty_left_b, duty_right_a,
    // duty_right_b, then zero padding to a whole byte.
    output logic [((4*DUTY_BITS+7)/8)*8-1:0]          m_axis_tdata,
    // tuser from bit 0 up: bridge_enable.
    output logic [0:0]                                m_axis_tuser,

    // Configuration write channel.
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0]                  cfg_addr,
    input  logic [3*CHANNEL_BITS-1:0]                 cfg_data
);

    localparam int OUT_W = ((4*DUTY_BITS+7)/8)*8;

    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic [DUTY_BITS-1:0] duty_left_a;
    logic [DUTY_BITS-1:0] duty_left_b;
    logic [DUTY_BITS-1:0] duty_right_a;
    logic [DUTY_BITS-1:0] duty_right_b;
    logic               bridge_enable;

    // Configuration registers are plain flops and take a write every cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences the frame: capture, arm check, three divider
    // passes (aileron, elevator, rudder), then the mix into the held outputs.
    rcdz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the captured frame, the shared
    // divider and the held duties, which double as the output register.
    rcdz_datapath #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .DUTY_BITS    (DUTY_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .ch_aileron    (s_axis_tdata[CHANNEL_BITS-1:0]),
        .ch_elevator   (s_axis_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
        .ch_rudder     (s_axis_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
        .ch_arm        (s_axis_tdata[4*CHANNEL_BITS-1:3*CHANNEL_BITS]),
        .failsafe_flag (s_axis_tuser[0]),
        .frame_lost    (s_axis_tuser[1]),
        .cmd           (cmd),
        .status        (status),
        .duty_left_a   (duty_left_a),
        .duty_left_b   (duty_left_b),
        .duty_right_a  (duty_right_a),
        .duty_right_b  (duty_right_b),
        .bridge_enable (bridge_enable)
    );

    // The held values stay stable while a result waits, because a new
    // result is only written once the output register is free.
    assign m_axis_tdata = OUT_W'({duty_right_b, duty_right_a, duty_left_b, duty_left_a});
    assign m_axis_tuser = bridge_enable;

endmodule

[hw/rtl/rcdz_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
module rcdz_divider
    import rcdz_pkg::*;
#(
    parameter int DIVIDEND_BITS = 19,
    parameter int DIVISOR_BITS  = 11
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic                     done
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

    logic                     busy_reg;
    logic                     busy_next;
    logic                     done_reg;
    logic                     done_next;
    logic [CNT_BITS-1:0]      count_reg;
    logic [CNT_BITS-1:0]      count_next;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVIDEND_BITS-1:0] quo_next;
    logic [DIVISOR_BITS-1:0]  divisor_reg;
    logic [DIVISOR_BITS-1:0]  divisor_next;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    // The dividend shifts out of the top of the quotient register while
    // quotient bits shift in at the bottom.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = (shifted >= {1'b0, divisor_reg});
    end

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
            quo_next   = {quo_reg[DIVIDEND_BITS-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_BITS'(DIVIDEND_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

[hw/rtl/rcdz_datapath.sv]
// Datapath: configuration registers, axis scaling, mixing and held outputs.
module rcdz_datapath
    import rcdz_pkg::*;
#(
    parameter int CHANNEL_BITS = 11,
    parameter int DUTY_BITS    = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [3*CHANNEL_BITS-1:0]   cfg_data,
    input  logic [CHANNEL_BITS-1:0]     ch_aileron,
    input  logic [CHANNEL_BITS-1:0]     ch_elevator,
    input  logic [CHANNEL_BITS-1:0]     ch_rudder,
    input  logic [CHANNEL_BITS-1:0]     ch_arm,
    input  logic                        failsafe_flag,
    input  logic                        frame_lost,
    input  ctrl_cmd_t                   cmd,
    output dp_status_t                  status,
    output logic [DUTY_BITS-1:0]        duty_left_a,
    output logic [DUTY_BITS-1:0]        duty_left_b,
    output logic [DUTY_BITS-1:0]        duty_right_a,
    output logic [DUTY_BITS-1:0]        duty_right_b,
    output logic                        bridge_enable
);

    localparam int CB   = CHANNEL_BITS;
    localparam int DB   = DUTY_BITS;
    localparam int EXT  = CB + 2;
    localparam int DIVW = CB + DB;
    localparam int MIXW = DB + 2;

    localparam logic [DB-1:0] DUTY_MAX = {DB{1'b1}};

    // Configuration registers.
    logic [3*CB-1:0] elevator_cal_reg;
    logic [3*CB-1:0] aileron_cal_reg;
    logic [3*CB-1:0] rudder_cal_reg;
    logic [CB-1:0]   arm_threshold_reg;
    logic [CB-1:0]   dead_band_reg;
    logic            hard_stop_reg;

    // Captured frame.
    logic [CB-1:0]   ail_reg;
    logic [CB-1:0]   ele_reg;
    logic [CB-1:0]   rud_reg;
    logic [CB-1:0]   arm_reg;
    logic            failsafe_reg;
    logic            lost_reg;

    // Per-axis classification latched when the divider starts.
    logic            ax_upper_reg;
    logic            ax_lower_reg;
    logic            ax_sat_reg;
    logic            ax_kill_reg;

    // Signed axis values.
    logic signed [DB:0] x_reg;
    logic signed [DB:0] y_reg;
    logic signed [DB:0] z_reg;

    // Held outputs.
    logic [DB-1:0]   held_duty_reg [4];
    logic [DB-1:0]   held_duty_next [4];
    logic            held_enable_reg;
    logic            held_enable_next;

    logic            disarm;

    logic [CB-1:0]   ch_sel;
    logic [3*CB-1:0] cal_sel;
    logic signed [EXT-1:0] ch_e;
    logic signed [EXT-1:0] lo_e;
    logic signed [EXT-1:0] mid_e;
    logic signed [EXT-1:0] hi_e;
    logic signed [EXT-1:0] dz_e;
    logic signed [EXT-1:0] span_e;
    logic signed [EXT-1:0] num_e;
    logic            upper;
    logic            lower;
    logic            span_zero;
    logic            span_neg;
    logic [CB-1:0]   span_mag;
    logic [CB-1:0]   num_mag;
    logic            kill;
    logic [DIVW-1:0] dividend;

    logic [DIVW-1:0] quotient;
    logic            div_done;
    logic [DB-1:0]   quo_sat;
    logic [DB-1:0]   mag;
    logic signed [DB:0] axis_val;

    logic signed [MIXW-1:0] xe;
    logic signed [MIXW-1:0] ye;
    logic signed [MIXW-1:0] ze;
    logic signed [MIXW-1:0] mix_d [4];
    logic [DB-1:0]   mix_duty [4];
    logic            any_axis;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elevator_cal_reg  <= {3{CB'(CAL_RESET_VALUE)}};
            aileron_cal_reg   <= {3{CB'(CAL_RESET_VALUE)}};
            rudder_cal_reg    <= {3{CB'(CAL_RESET_VALUE)}};
            arm_threshold_reg <= CB'(ARM_RESET_VALUE);
            dead_band_reg     <= CB'(DEAD_BAND_RESET);
            hard_stop_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_ELEVATOR_CAL:  elevator_cal_reg  <= cfg_data;
                REG_AILERON_CAL:   aileron_cal_reg   <= cfg_data;
                REG_RUDDER_CAL:    rudder_cal_reg    <= cfg_data;
                REG_ARM_THRESHOLD: arm_threshold_reg <= cfg_data[CB-1:0];
                REG_DEAD_BAND:     dead_band_reg     <= cfg_data[CB-1:0];
                REG_HARD_STOP:     hard_stop_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ail_reg      <= ch_aileron;
            ele_reg      <= ch_elevator;
            rud_reg      <= ch_rudder;
            arm_reg      <= ch_arm;
            failsafe_reg <= failsafe_flag;
            lost_reg     <= frame_lost;
        end
    end

    assign disarm = (arm_reg < arm_threshold_reg) || failsafe_reg;
    assign status.skip     = disarm || lost_reg;
    assign status.div_done = div_done;

    // Axis setup: pick the channel and its calibration, classify the
    // position against the dead band and form |ch-mid|*DUTY_MAX.
    always_comb
    begin
        case (cmd.axis)
            AXIS_AIL:
            begin
                ch_sel  = ail_reg;
                cal_sel = aileron_cal_reg;
            end
            AXIS_ELE:
            begin
                ch_sel  = ele_reg;
                cal_sel = elevator_cal_reg;
            end
            AXIS_RUD:
            begin
                ch_sel  = rud_reg;
                cal_sel = rudder_cal_reg;
            end
            default:
            begin
                ch_sel  = rud_reg;
                cal_sel = rudder_cal_reg;
            end
        endcase
        ch_e  = signed'({2'b00, ch_sel});
        lo_e  = signed'({2'b00, cal_sel[CB-1:0]});
        mid_e = signed'({2'b00, cal_sel[2*CB-1:CB]});
        hi_e  = signed'({2'b00, cal_sel[3*CB-1:2*CB]});
        dz_e  = signed'({2'b00, dead_band_reg});
        upper = (ch_e >= mid_e + dz_e);
        lower = !upper && (ch_e < mid_e - dz_e);
        span_e    = (upper ? hi_e : lo_e) - mid_e;
        span_zero = (span_e == '0);
        span_neg  = span_e[EXT-1];
        span_mag  = span_neg ? CB'(-span_e) : span_e[CB-1:0];
        num_e     = upper ? (ch_e - mid_e) : (mid_e - ch_e);
        num_mag   = num_e[CB-1:0];
        // An end point on the wrong side of mid gives a negative quotient.
        kill      = upper ? span_neg : (!span_neg && !span_zero);
        dividend  = {num_mag, {DB{1'b0}}} - DIVW'(num_mag);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            ax_upper_reg <= upper;
            ax_lower_reg <= lower;
            ax_sat_reg   <= span_zero;
            ax_kill_reg  <= kill;
        end
    end

    rcdz_divider #(
        .DIVIDEND_BITS (DIVW),
        .DIVISOR_BITS  (CB)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (span_mag),
        .quotient (quotient),
        .done     (div_done)
    );

    // Axis finish: clamp the quotient and apply the side of the band.
    always_comb
    begin
        quo_sat = (|quotient[DIVW-1:DB]) ? DUTY_MAX : quotient[DB-1:0];
        if ((!ax_upper_reg && !ax_lower_reg) || ax_kill_reg)
        begin
            mag = '0;
        end
        else if (ax_sat_reg)
        begin
            mag = DUTY_MAX;
        end
        else
        begin
            mag = quo_sat;
        end
        axis_val = ax_lower_reg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            case (cmd.axis)
                AXIS_AIL: x_reg <= axis_val;
                AXIS_ELE: y_reg <= axis_val;
                AXIS_RUD: z_reg <= axis_val;
                default:  ;
            endcase
        end
    end

    // Skid-steer mixing: rotation first, then forward or backward drive
    // with an optional turn.
    always_comb
    begin
        xe = {x_reg[DB], x_reg};
        ye = {y_reg[DB], y_reg};
        ze = {z_reg[DB], z_reg};
        for (int i = 0; i < 4; i++)
        begin
            mix_d[i] = '0;
        end
        if (ze > 0)
        begin
            mix_d[1] = ze;
            mix_d[2] = ze;
        end
        else if (ze < 0)
        begin
            mix_d[0] = -ze;
            mix_d[3] = -ze;
        end
        else if (ye > 0)
        begin
            if (xe > 0)
            begin
                mix_d[1] = ye;
                mix_d[3] = ye - xe;
            end
            else if (xe == 0)
            begin
                mix_d[1] = ye;
                mix_d[3] = ye;
            end
            else
            begin
                mix_d[1] = ye + xe;
                mix_d[3] = ye;
            end
        end
        else if (ye < 0)
        begin
            if (xe == 0)
            begin
                mix_d[0] = -ye;
                mix_d[2] = -ye;
            end
            else if (xe > 0)
            begin
                mix_d[0] = -ye;
                mix_d[2] = -ye - xe;
            end
            else
            begin
                mix_d[0] = -ye + xe;
                mix_d[2] = -ye;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (mix_d[i] < 0)
            begin
                mix_duty[i] = '0;
            end
            else if (mix_d[i] > signed'({2'b00, DUTY_MAX}))
            begin
                mix_duty[i] = DUTY_MAX;
            end
            else
            begin
                mix_duty[i] = mix_d[i][DB-1:0];
            end
        end
        any_axis = (x_reg != '0) || (y_reg != '0) || (z_reg != '0);
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            held_duty_next[i] = held_duty_reg[i];
        end
        held_enable_next = held_enable_reg;
        if (cmd.finish)
        begin
            if (disarm)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    held_duty_next[i] = '0;
                end
                held_enable_next = 1'b0;
            end
            else if (!lost_reg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    held_duty_next[i] = mix_duty[i];
                end
                held_enable_next = any_axis || hard_stop_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                held_duty_reg[i] <= '0;
            end
            held_enable_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                held_duty_reg[i] <= held_duty_next[i];
            end
            held_enable_reg <= held_enable_next;
        end
    end

    assign duty_left_a   = held_duty_reg[0];
    assign duty_left_b   = held_duty_reg[1];
    assign duty_right_a  = held_duty_reg[2];
    assign duty_right_b  = held_duty_reg[3];
    assign bridge_enable = held_enable_reg;

    a_disarm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && disarm) |=> (!held_enable_reg && held_duty_reg[0] == '0
            && held_duty_reg[1] == '0 && held_duty_reg[2] == '0
            && held_duty_reg[3] == '0))
        else $error("disarmed frame left a duty or the enable set");

endmodule

[hw/rtl/rcdz_ctrl.sv]
// Controller: frame sequencing, shared divider scheduling and output valid.
module rcdz_ctrl
    import rcdz_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    axis_t  axis_reg;
    axis_t  axis_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                axis_next  = AXIS_AIL;
                state_next = status.skip ? ST_FINISH : ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                case (axis_reg)
                    AXIS_AIL:
                    begin
                        axis_next  = AXIS_ELE;
                        state_next = ST_SETUP;
                    end
                    AXIS_ELE:
                    begin
                        axis_next  = AXIS_RUD;
                        state_next = ST_SETUP;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.store     = 1'b0;
        cmd.finish    = 1'b0;
        cmd.axis      = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SETUP:
            begin
                cmd.div_start = 1'b1;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_AIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_DIV))
        else $error("divider result arrived outside the wait state");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result published without a finish step");

endmodule

[bench/rc_deadzone_skid_steer_mixer_unit_tb.sv]
// Self-checking testbench for the dead-zone skid-steer mixer: directed and random frames.
module rc_deadzone_skid_steer_mixer_unit_tb;

    import rcdz_pkg::*;

    localparam int CH_W      = 11;
    localparam int DUTY_W    = 8;
    localparam int IN_W      = ((4*CH_W+7)/8)*8;
    localparam int OUT_W     = ((4*DUTY_W+7)/8)*8;
    localparam int CAL_W     = 3*CH_W;
    localparam int DUTY_FULL = (1 << DUTY_W) - 1;
    localparam int CH_TOP    = (1 << CH_W) - 1;

    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PCT       = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 80;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RANDOM_PHASES  = 8;
    localparam int FRAMES_PER_SET = 175;
    // Neither side idles inside this window of cycles.
    localparam int QUIET_FROM     = 30000;
    localparam int QUIET_TO       = 45000;

    localparam logic [CAL_W-1:0] CAL_DEFAULT = {3{CH_W'(CAL_RESET_VALUE)}};

    typedef enum logic [1:0]
    {
        STEP_FRAME,
        STEP_WRITE,
        STEP_DRAIN
    } step_kind_t;

    // One entry of the stimulus list: a radio frame, a register write or a
    // pause until every duty result has come back.
    typedef struct
    {
        step_kind_t       kind;
        logic [CH_W-1:0]  ail;
        logic [CH_W-1:0]  ele;
        logic [CH_W-1:0]  rud;
        logic [CH_W-1:0]  arm;
        logic             failsafe;
        logic             lost;
        cfg_reg_t         reg_sel;
        logic [CAL_W-1:0] wdata;
    } stim_step_t;

    // Duties in the order left_a, left_b, right_a, right_b.
    typedef struct packed
    {
        logic                   enable;
        logic [3:0][DUTY_W-1:0] duty;
    } bridge_out_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_addr   = REG_ELEVATOR_CAL;
    logic [CAL_W-1:0]      cfg_data      = '0;

    rc_deadzone_skid_steer_mixer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Stimulus list, filled up front, and the duty results still owed by the block.
    stim_step_t  pending[$];
    bridge_out_t duty_q[$];
    stim_step_t  on_bus;
    int          hold_off;

    int n_predicted = 0;
    int n_taken     = 0;
    int n_errors    = 0;
    int n_frames    = 0;
    int n_writes    = 0;
    int n_disarmed  = 0;
    int n_held      = 0;
    int cycles      = 0;

    wire quiet = (cycles >= QUIET_FROM) && (cycles < QUIET_TO);

    string duty_name[4] = '{"duty_left_a", "duty_left_b", "duty_right_a", "duty_right_b"};

    // Mirror of the block's registers and held outputs, updated as requests are accepted.
    logic [CAL_W-1:0]       ele_cal;
    logic [CAL_W-1:0]       ail_cal;
    logic [CAL_W-1:0]       rud_cal;
    logic [CH_W-1:0]        arm_level;
    logic [CH_W-1:0]        band_half;
    logic                   keep_enable;
    logic [3:0][DUTY_W-1:0] held_duty;
    logic                   held_en;

    // What the stimulus generator believes the registers will hold.
    logic [CAL_W-1:0] plan_ele;
    logic [CAL_W-1:0] plan_ail;
    logic [CAL_W-1:0] plan_rud;
    int               plan_arm;
    int               plan_band;

    function automatic int clamp_duty(int v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > DUTY_FULL)
        begin
            return DUTY_FULL;
        end
        return v;
    endfunction

    // Linear stretch from the center toward one calibrated end point. A zero
    // span saturates; an end point on the wrong side of center clamps to zero.
    function automatic int scale_toward(int ch, int mid, int end_pt);
        int span;
        span = end_pt - mid;
        if (span == 0)
        begin
            return DUTY_FULL;
        end
        return clamp_duty(((ch - mid) * DUTY_FULL) / span);
    endfunction

    // Signed stick deflection, zero inside the dead band.
    function automatic int stick_deflection(logic [CH_W-1:0] raw, logic [CAL_W-1:0] cal);
        int ch;
        int lo;
        int mid;
        int hi;
        int dz;
        ch  = int'(raw);
        lo  = int'(cal[CH_W-1:0]);
        mid = int'(cal[2*CH_W-1:CH_W]);
        hi  = int'(cal[3*CH_W-1:2*CH_W]);
        dz  = int'(band_half);
        if (ch >= mid + dz)
        begin
            return scale_toward(ch, mid, hi);
        end
        if (ch < mid - dz)
        begin
            return -scale_toward(ch, mid, lo);
        end
        return 0;
    endfunction

    task automatic apply_write(cfg_reg_t sel, logic [CAL_W-1:0] value);
        case (sel)
            REG_ELEVATOR_CAL:  ele_cal     = value;
            REG_AILERON_CAL:   ail_cal     = value;
            REG_RUDDER_CAL:    rud_cal     = value;
            REG_ARM_THRESHOLD: arm_level   = value[CH_W-1:0];
            REG_DEAD_BAND:     band_half   = value[CH_W-1:0];
            REG_HARD_STOP:     keep_enable = value[0];
            default:           ;
        endcase
    endtask

    // Works out the duties for one accepted frame and queues them.
    task automatic mix_frame(stim_step_t r);
        int x;
        int y;
        int z;
        int d[4];
        int k;
        bridge_out_t w;
        if (r.arm < arm_level || r.failsafe)
        begin
            held_duty = '0;
            held_en   = 1'b0;
            n_disarmed++;
        end
        else if (r.lost)
        begin
            n_held++;
        end
        else
        begin
            x = stick_deflection(r.ail, ail_cal);
            y = stick_deflection(r.ele, ele_cal);
            z = stick_deflection(r.rud, rud_cal);
            d = '{0, 0, 0, 0};
            // Rotation on the rudder wins over driving.
            if (z > 0)
            begin
                d[1] = z;
                d[2] = z;
            end
            else if (z < 0)
            begin
                d[0] = -z;
                d[3] = -z;
            end
            else if (y > 0)
            begin
                if (x > 0)
                begin
                    d[1] = y;
                    d[3] = y - x;
                end
                else if (x == 0)
                begin
                    d[1] = y;
                    d[3] = y;
                end
                else
                begin
                    d[1] = y + x;
                    d[3] = y;
                end
            end
            else if (y < 0)
            begin
                if (x == 0)
                begin
                    d[0] = -y;
                    d[2] = -y;
                end
                else if (x > 0)
                begin
                    d[0] = -y;
                    d[2] = -y - x;
                end
                else
                begin
                    d[0] = -y + x;
                    d[2] = -y;
                end
            end
            held_en = (x != 0 || y != 0 || z != 0 || keep_enable);
            for (k = 0; k < 4; k++)
            begin
                held_duty[k] = DUTY_W'(clamp_duty(d[k]));
            end
        end
        w.duty   = held_duty;
        w.enable = held_en;
        duty_q.push_back(w);
        n_predicted++;
    endtask

    // Driver: presents frames and register writes from the pending list and
    // feeds every accepted request into the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        logic frame_busy;
        logic write_busy;
        logic next_frame;
        logic next_write;
        int   still_owed;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            cfg_valid     <= 1'b0;
            cfg_addr      <= REG_ELEVATOR_CAL;
            cfg_data      <= '0;
            hold_off      = 0;
            ele_cal       = CAL_DEFAULT;
            ail_cal       = CAL_DEFAULT;
            rud_cal       = CAL_DEFAULT;
            arm_level     = CH_W'(ARM_RESET_VALUE);
            band_half     = CH_W'(DEAD_BAND_RESET);
            keep_enable   = 1'b0;
            held_duty     = '0;
            held_en       = 1'b0;
        end
        else
        begin
            frame_busy = s_axis_tvalid && !s_axis_tready;
            write_busy = cfg_valid && !cfg_ready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                mix_frame(on_bus);
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_write(on_bus.reg_sel, on_bus.wdata);
            end
            next_frame = frame_busy;
            next_write = write_busy;
            // A result taken at this very edge no longer counts as owed.
            still_owed = n_predicted - n_taken - ((m_axis_tvalid && m_axis_tready) ? 1 : 0);
            if (!frame_busy && !write_busy)
            begin
                if (hold_off > 0)
                begin
                    hold_off--;
                end
                else if (pending.size() != 0)
                begin
                    case (pending[0].kind)
                        STEP_DRAIN:
                        begin
                            if (still_owed <= 0)
                            begin
                                pending.delete(0);
                                hold_off = SETTLE_CYCLES;
                            end
                        end
                        STEP_WRITE:
                        begin
                            on_bus = pending.pop_front();
                            next_write = 1'b1;
                        end
                        default:
                        begin
                            if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
                            begin
                                hold_off = $urandom_range(1, 75);
                            end
                            else
                            begin
                                on_bus = pending.pop_front();
                                next_frame = 1'b1;
                            end
                        end
                    endcase
                end
            end
            s_axis_tvalid <= next_frame;
            cfg_valid     <= next_write;
            if (next_frame && !frame_busy)
            begin
                s_axis_tdata <= IN_W'({on_bus.arm, on_bus.rud, on_bus.ele, on_bus.ail});
                s_axis_tuser <= {on_bus.lost, on_bus.failsafe};
            end
            if (next_write && !write_busy)
            begin
                cfg_addr <= on_bus.reg_sel;
                cfg_data <= on_bus.wdata;
            end
        end
    end

    // Monitor: takes duty results under random back-pressure and checks each
    // against the oldest queued expectation.
    always @(posedge clk or negedge rst_n)
    begin
        bridge_out_t want;
        bridge_out_t got;
        int          k;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.duty   = m_axis_tdata[4*DUTY_W-1:0];
                got.enable = m_axis_tuser[0];
                if (duty_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got duties %h enable %0b",
                             $time, got.duty, got.enable);
                    n_errors++;
                end
                else
                begin
                    want = duty_q.pop_front();
                    for (k = 0; k < 4; k++)
                    begin
                        if (got.duty[k] !== want.duty[k])
                        begin
                            $display("%0t: %s expected %0d, got %0d",
                                     $time, duty_name[k], want.duty[k], got.duty[k]);
                            n_errors++;
                        end
                    end
                    if (got.enable !== want.enable)
                    begin
                        $display("%0t: bridge_enable expected %0b, got %0b",
                                 $time, want.enable, got.enable);
                        n_errors++;
                    end
                end
                n_taken <= n_taken + 1;
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [CAL_W-1:0] cal_word(int lo, int mid, int hi);
        return {CH_W'(hi), CH_W'(mid), CH_W'(lo)};
    endfunction

    function automatic logic [CAL_W-1:0] typical_cal();
        return cal_word($urandom_range(0, 400), $urandom_range(900, 1150),
                        $urandom_range(1600, CH_TOP));
    endfunction

    function automatic logic [CAL_W-1:0] random_word();
        logic [CAL_W-1:0] w;
        w[31:0]       = $urandom;
        w[CAL_W-1:32] = (CAL_W-32)'($urandom);
        return w;
    endfunction

    task automatic add_frame(int ail, int ele, int rud, int arm, logic fs, logic lost);
        stim_step_t s;
        s.kind     = STEP_FRAME;
        s.ail      = CH_W'(ail);
        s.ele      = CH_W'(ele);
        s.rud      = CH_W'(rud);
        s.arm      = CH_W'(arm);
        s.failsafe = fs;
        s.lost     = lost;
        s.reg_sel  = REG_ELEVATOR_CAL;
        s.wdata    = '0;
        pending.push_back(s);
        n_frames++;
    endtask

    // Unused upper data bits of the narrow registers carry random junk.
    task automatic add_write(cfg_reg_t sel, logic [CAL_W-1:0] value);
        stim_step_t s;
        s = '{kind: STEP_WRITE, ail: '0, ele: '0, rud: '0, arm: '0, failsafe: 1'b0,
              lost: 1'b0, reg_sel: sel, wdata: value};
        case (sel)
            REG_ELEVATOR_CAL:  plan_ele  = value;
            REG_AILERON_CAL:   plan_ail  = value;
            REG_RUDDER_CAL:    plan_rud  = value;
            REG_ARM_THRESHOLD: plan_arm  = int'(value[CH_W-1:0]);
            REG_DEAD_BAND:     plan_band = int'(value[CH_W-1:0]);
            default:           ;
        endcase
        pending.push_back(s);
        n_writes++;
    endtask

    task automatic add_drain();
        stim_step_t s;
        s = '{kind: STEP_DRAIN, ail: '0, ele: '0, rud: '0, arm: '0, failsafe: 1'b0,
              lost: 1'b0, reg_sel: REG_ELEVATOR_CAL, wdata: '0};
        pending.push_back(s);
    endtask

    task automatic add_narrow(cfg_reg_t sel, int value);
        logic [CAL_W-1:0] w;
        w = random_word();
        if (sel == REG_HARD_STOP)
        begin
            w[0] = value[0];
        end
        else
        begin
            w[CH_W-1:0] = CH_W'(value);
        end
        add_write(sel, w);
    endtask

    // Channel value around the axis calibration: near center, toward either
    // end, exactly at an end, at either extreme of the channel range, or anywhere.
    function automatic int pick_channel(logic [CAL_W-1:0] cal, int center_pct);
        int lo;
        int mid;
        int hi;
        int v;
        lo  = int'(cal[CH_W-1:0]);
        mid = int'(cal[2*CH_W-1:CH_W]);
        hi  = int'(cal[3*CH_W-1:2*CH_W]);
        if ($urandom_range(0, 99) < center_pct)
        begin
            v = mid + int'($urandom_range(0, 2*plan_band + 4)) - plan_band - 2;
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       v = $urandom_range(0, CH_TOP);
                1:       v = $urandom_range(lo, mid);
                2:       v = $urandom_range(mid, hi);
                3:       v = $urandom_range(0, 1) ? lo : hi;
                default: v = $urandom_range(0, 1) ? 0 : CH_TOP;
            endcase
        end
        if (v < 0)
        begin
            v = 0;
        end
        if (v > CH_TOP)
        begin
            v = CH_TOP;
        end
        return v;
    endfunction

    // Mostly armed frames with sticks placed around the calibration; the rest
    // are disarmed frames or fully random noise.
    task automatic add_random_frame();
        int pick;
        int arm;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            add_frame($urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
                      $urandom_range(0, CH_TOP), $urandom_range(0, CH_TOP),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            if (pick < 16 && plan_arm > 0)
            begin
                arm = $urandom_range(0, plan_arm - 1);
            end
            else
            begin
                arm = $urandom_range(plan_arm, CH_TOP);
            end
            add_frame(pick_channel(plan_ail, 25), pick_channel(plan_ele, 20),
                      pick_channel(plan_rud, 55), arm, 1'b0, $urandom_range(0, 99) < 8);
        end
    endtask

    initial
    begin
        int p;
        plan_ele  = CAL_DEFAULT;
        plan_ail  = CAL_DEFAULT;
        plan_rud  = CAL_DEFAULT;
        plan_arm  = ARM_RESET_VALUE;
        plan_band = DEAD_BAND_RESET;

        // Reset calibration has zero spans, so any deflection saturates.
        add_frame(1000, 1000, 1000, 1000, 1'b0, 1'b0);
        add_frame(1000, 1000, CH_TOP, 999, 1'b0, 1'b0);
        add_frame(1000, 1000, CH_TOP, CH_TOP, 1'b0, 1'b0);
        add_frame(1000, 1000, 0, CH_TOP, 1'b0, 1'b1);
        add_frame(1000, 1000, 0, CH_TOP, 1'b0, 1'b0);
        add_frame(1000, CH_TOP, 1000, CH_TOP, 1'b1, 1'b0);
        add_frame(CH_TOP, 0, 1000, CH_TOP, 1'b0, 1'b0);

        // Ordinary calibration: every drive case and the dead band edges.
        add_drain();
        add_write(REG_ELEVATOR_CAL, cal_word(172, 992, 1811));
        add_write(REG_AILERON_CAL, cal_word(172, 992, 1811));
        add_write(REG_RUDDER_CAL, cal_word(172, 992, 1811));
        add_narrow(REG_ARM_THRESHOLD, 1500);
        add_narrow(REG_DEAD_BAND, 30);
        add_narrow(REG_HARD_STOP, 0);
        add_frame(992, 1811, 992, CH_TOP, 1'b0, 1'b0);
        add_frame(1500, 1600, 992, CH_TOP, 1'b0, 1'b0);
        add_frame(400, 1600, 992, CH_TOP, 1'b0, 1'b0);
        add_frame(992, 172, 992, CH_TOP, 1'b0, 1'b0);
        add_frame(1500, 300, 992, CH_TOP, 1'b0, 1'b0);
        add_frame(400, 300, 992, CH_TOP, 1'b0, 1'b0);
        // Turning with no forward motion: duties zero, enable on.
        add_frame(1811, 992, 992, 1500, 1'b0, 1'b0);
        add_frame(992, 1811, 1500, CH_TOP, 1'b0, 1'b0);
        add_frame(992, 1022, 992, CH_TOP, 1'b0, 1'b0);
        add_frame(992, 962, 992, CH_TOP, 1'b0, 1'b0);
        add_frame(992, 961, 992, CH_TOP, 1'b0, 1'b0);
        add_frame(992, CH_TOP, 992, CH_TOP, 1'b0, 1'b0);

        // Hard stop, no dead band, threshold at zero, reversed aileron ends.
        add_drain();
        add_write(REG_AILERON_CAL, cal_word(1800, 1000, 200));
        add_narrow(REG_DEAD_BAND, 0);
        add_narrow(REG_ARM_THRESHOLD, 0);
        add_narrow(REG_HARD_STOP, 1);
        add_frame(1000, 992, 992, 0, 1'b0, 1'b0);
        add_frame(CH_TOP, 1811, 992, 0, 1'b0, 1'b0);
        add_frame(0, 172, 992, 0, 1'b0, 1'b0);
        add_frame(992, 1811, 992, 0, 1'b0, 1'b1);

        // Random frames under a rotating set of register settings; each set
        // is written only once the block has handed back every result.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            add_drain();
            case (p % 4)
                0:
                begin
                    add_write(REG_ELEVATOR_CAL, typical_cal());
                    add_write(REG_AILERON_CAL, typical_cal());
                    add_write(REG_RUDDER_CAL, typical_cal());
                    add_narrow(REG_ARM_THRESHOLD, $urandom_range(0, 1500));
                    add_narrow(REG_DEAD_BAND, $urandom_range(0, 60));
                    add_narrow(REG_HARD_STOP, $urandom_range(0, 1));
                end
                1:
                begin
                    add_write(REG_ELEVATOR_CAL, (p < 4) ? '0 : '1);
                    add_write(REG_AILERON_CAL, (p < 4) ? '1 : '0);
                    add_write(REG_RUDDER_CAL, typical_cal());
                    add_narrow(REG_ARM_THRESHOLD, 0);
                    add_narrow(REG_DEAD_BAND, 0);
                    add_narrow(REG_HARD_STOP, 1);
                end
                2:
                begin
                    add_write(REG_ELEVATOR_CAL, typical_cal());
                    add_write(REG_AILERON_CAL, typical_cal());
                    add_write(REG_RUDDER_CAL, typical_cal());
                    add_narrow(REG_ARM_THRESHOLD, CH_TOP);
                    add_narrow(REG_DEAD_BAND, (p < 4) ? CH_TOP : $urandom_range(0, 10));
                    add_narrow(REG_HARD_STOP, 0);
                end
                default:
                begin
                    add_write(REG_ELEVATOR_CAL, random_word());
                    add_write(REG_AILERON_CAL, random_word());
                    add_write(REG_RUDDER_CAL, random_word());
                    add_narrow(REG_ARM_THRESHOLD, $urandom_range(0, CH_TOP));
                    add_narrow(REG_DEAD_BAND, $urandom_range(0, CH_TOP));
                    add_narrow(REG_HARD_STOP, $urandom_range(0, 1));
                end
            endcase
            repeat (FRAMES_PER_SET) add_random_frame();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_axis_tvalid || cfg_valid || n_taken < n_predicted)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (duty_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, duty_q.size());
            n_errors += duty_q.size();
        end
        $display("Covered %0d frames (%0d disarmed, %0d held on a lost frame) and %0d writes",
                 n_frames, n_disarmed, n_held, n_writes);
        $display("over %0d register settings; %0d duty results compared, %0d mismatches.",
                 RANDOM_PHASES + 3, n_taken, n_errors);
        if (n_errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
